>>> hdl/signed_divider_rounding_modes_defines.svh
// Assertion macros for the signed divider with rounding modes.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SIGNED_DIVIDER_ROUNDING_MODES_DEFINES_SVH
`define SIGNED_DIVIDER_ROUNDING_MODES_DEFINES_SVH
`ifndef SYNTHESIS
`define SDRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDRM_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SDRM_ASSERT(label, prop, msg)
`define SDRM_ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> hdl/sdrm_pkg.sv
// Shared constants and types for the signed divider with rounding modes.
// No dependencies; imported by every module of the block.
`default_nettype none
package sdrm_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    localparam logic [1:0] OP_TQUO = 2'd0;
    localparam logic [1:0] OP_FQUO = 2'd1;
    localparam logic [1:0] OP_FMOD = 2'd2;
    localparam logic [1:0] OP_TREM = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       na;
        logic       nb;
        logic       div0;
    } ctl_t;

endpackage
`default_nettype wire

>>> hdl/sdrm_if.sv
// Request and response channel interfaces of the signed divider.
// Depends on nothing; used by the top level and its edge stages.
`default_nettype none
interface sdrm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [63:0] dividend;
    logic signed [63:0] divisor;

    modport source (output valid, output op, output dividend, output divisor, input ready);
    modport sink (input valid, input op, input dividend, input divisor, output ready);
endinterface

interface sdrm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/signed_divider_rounding_modes.sv
// Top level of the pipelined signed divider with four rounding modes.
// Depends on sdrm_pkg, sdrm_if, sdrm_pre, sdrm_cell and sdrm_post.
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  op[1:0], dividend[63:0], divisor[63:0]
//  rsp      out  valid/ready  value[63:0], status[1:0]
//
// One request per cycle while rsp.ready holds; stages are an entry stage,
// one cell per quotient bit and an output register.
// The cells form a chain of DATA_WIDTH restoring-division cells.
// Reset clears valid flags only; no clearing pass.
// A stalled response holds; empty stages upstream still fill.
`default_nettype none
module signed_divider_rounding_modes
    import sdrm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdrm_req_if.sink   req,
    sdrm_rsp_if.source rsp
);

    logic                  valid_s [0:DATA_WIDTH];
    logic                  ready_s [0:DATA_WIDTH];
    ctl_t                  ctl_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_s    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] ub_s    [0:DATA_WIDTH];

    sdrm_pre #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pre (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dn_valid (valid_s[0]),
        .dn_ready (ready_s[0]),
        .dn_ctl   (ctl_s[0]),
        .dn_rem   (rem_s[0]),
        .dn_dq    (dq_s[0]),
        .dn_ub    (ub_s[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_cell
        sdrm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_s[k]),
            .up_ready (ready_s[k]),
            .up_ctl   (ctl_s[k]),
            .up_rem   (rem_s[k]),
            .up_dq    (dq_s[k]),
            .up_ub    (ub_s[k]),
            .dn_valid (valid_s[k+1]),
            .dn_ready (ready_s[k+1]),
            .dn_ctl   (ctl_s[k+1]),
            .dn_rem   (rem_s[k+1]),
            .dn_dq    (dq_s[k+1]),
            .dn_ub    (ub_s[k+1])
        );
    end

    sdrm_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_s[DATA_WIDTH]),
        .up_ready (ready_s[DATA_WIDTH]),
        .up_ctl   (ctl_s[DATA_WIDTH]),
        .up_rem   (rem_s[DATA_WIDTH]),
        .up_dq    (dq_s[DATA_WIDTH]),
        .up_ub    (ub_s[DATA_WIDTH]),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

>>> hdl/sdrm_pre.sv
// Entry stage: takes a request, forms operand magnitudes, signs and flags.
// Depends on sdrm_pkg and sdrm_req_if; feeds the first division cell.
`default_nettype none
module sdrm_pre
    import sdrm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sdrm_req_if.sink                   req,
    output      logic                  dn_valid,
    input  wire logic                  dn_ready,
    output      ctl_t                  dn_ctl,
    output      logic [DATA_WIDTH-1:0] dn_rem,
    output      logic [DATA_WIDTH-1:0] dn_dq,
    output      logic [DATA_WIDTH-1:0] dn_ub
);

    logic                  valid_reg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [DATA_WIDTH-1:0] ua_reg;
    logic [DATA_WIDTH-1:0] ua_next;
    logic [DATA_WIDTH-1:0] ub_reg;
    logic [DATA_WIDTH-1:0] ub_next;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic                  bzero;
    logic                  take;

    assign req.ready = !valid_reg || dn_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        a     = req.dividend[DATA_WIDTH-1:0];
        b     = req.divisor[DATA_WIDTH-1:0];
        bzero = (b == '0);
        ctl_next.op = req.op;
        ctl_next.na = a[DATA_WIDTH-1];
        ua_next     = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        if (bzero && req.op[1])
        begin
            ctl_next.nb   = 1'b0;
            ctl_next.div0 = 1'b0;
            ub_next       = DATA_WIDTH'(1);
        end
        else
        begin
            ctl_next.nb   = b[DATA_WIDTH-1];
            ctl_next.div0 = bzero;
            ub_next       = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg <= ctl_next;
            ua_reg  <= ua_next;
            ub_reg  <= ub_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = '0;
    assign dn_dq    = ua_reg;
    assign dn_ub    = ub_reg;

endmodule
`default_nettype wire

>>> hdl/sdrm_cell.sv
// One restoring division cell: a single quotient bit per stage.
// Depends on sdrm_pkg; chained DATA_WIDTH times by the top level.
`default_nettype none
`include "signed_divider_rounding_modes_defines.svh"
module sdrm_cell
    import sdrm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output      logic                  up_ready,
    input  wire ctl_t                  up_ctl,
    input  wire logic [DATA_WIDTH-1:0] up_rem,
    input  wire logic [DATA_WIDTH-1:0] up_dq,
    input  wire logic [DATA_WIDTH-1:0] up_ub,
    output      logic                  dn_valid,
    input  wire logic                  dn_ready,
    output      ctl_t                  dn_ctl,
    output      logic [DATA_WIDTH-1:0] dn_rem,
    output      logic [DATA_WIDTH-1:0] dn_dq,
    output      logic [DATA_WIDTH-1:0] dn_ub
);

    logic                  valid_reg;
    ctl_t                  ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] dq_next;
    logic [DATA_WIDTH-1:0] ub_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        shifted  = {up_rem, up_dq[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, up_ub};
        fits     = !diff[DATA_WIDTH];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        dq_next  = {up_dq[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            ctl_reg <= up_ctl;
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            ub_reg  <= up_ub;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_dq    = dq_reg;
    assign dn_ub    = ub_reg;

    // partial remainder stays below the divisor magnitude
    `SDRM_ASSERT(a_rem_below_ub, valid_reg && !ctl_reg.div0 |-> rem_reg < ub_reg, "partial remainder not below divisor")
    `SDRM_ASSERT(a_stall_holds, valid_reg && !dn_ready |=> valid_reg && $stable(rem_reg), "stalled cell lost its data")
    `SDRM_ASSERT_NEVER(a_ready_when_empty, !valid_reg && !up_ready, "empty cell refused data")

endmodule
`default_nettype wire

>>> hdl/sdrm_post.sv
// Exit stage: applies rounding mode, sign, saturation and status, then
// holds the response in an output register. Depends on sdrm_pkg, sdrm_rsp_if.
`default_nettype none
`include "signed_divider_rounding_modes_defines.svh"
module sdrm_post
    import sdrm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output      logic                  up_ready,
    input  wire ctl_t                  up_ctl,
    input  wire logic [DATA_WIDTH-1:0] up_rem,
    input  wire logic [DATA_WIDTH-1:0] up_dq,
    input  wire logic [DATA_WIDTH-1:0] up_ub,
    sdrm_rsp_if.source                 rsp
);

    localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic                  valid_reg;
    logic signed [63:0]    value_reg;
    logic signed [63:0]    value_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [DATA_WIDTH-1:0] val_w;
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] r;
    logic                  diff_sign;

    assign up_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        q           = up_dq;
        r           = up_rem;
        diff_sign   = up_ctl.na != up_ctl.nb;
        val_w       = '0;
        status_next = ST_OK;
        if (up_ctl.div0)
        begin
            status_next = ST_DIV0;
        end
        else
        begin
            case (up_ctl.op)
                OP_TQUO:
                begin
                    if (!diff_sign && q[DATA_WIDTH-1])
                    begin
                        val_w       = MAXPOS;
                        status_next = ST_OVF;
                    end
                    else
                    begin
                        val_w = diff_sign ? (~q + 1'b1) : q;
                    end
                end
                OP_FQUO:
                begin
                    if (!diff_sign)
                    begin
                        if (q[DATA_WIDTH-1])
                        begin
                            val_w       = MAXPOS;
                            status_next = ST_OVF;
                        end
                        else
                        begin
                            val_w = q;
                        end
                    end
                    else
                    begin
                        // -(q + 1) when inexact
                        val_w = (r != '0) ? ~q : (~q + 1'b1);
                    end
                end
                OP_FMOD:
                begin
                    if (r != '0 && diff_sign)
                    begin
                        val_w = up_ctl.nb ? (r - up_ub) : (up_ub - r);
                    end
                    else
                    begin
                        val_w = up_ctl.na ? (~r + 1'b1) : r;
                    end
                end
                default:
                begin
                    val_w = up_ctl.na ? (~r + 1'b1) : r;
                end
            endcase
        end
        value_next = 64'($signed(val_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid  = valid_reg;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

    `SDRM_ASSERT_NEVER(a_status_code, valid_reg && status_reg == 2'd3, "undefined status code")
    `SDRM_ASSERT(a_div0_zero, valid_reg && status_reg == ST_DIV0 |-> value_reg == 64'sd0, "divide by zero with nonzero value")
    `SDRM_ASSERT(a_ovf_max, valid_reg && status_reg == ST_OVF |-> value_reg == 64'(MAXPOS), "overflow not saturated")
    `SDRM_ASSERT(a_fill, up_valid && up_ready |=> valid_reg, "accepted result not presented")

endmodule
`default_nettype wire
